>>> hw/rtl/typed_varint_encoder_macros.svh
// ----------------------------------------------------------------------------
// typed_varint_encoder assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TYPED_VARINT_ENCODER_MACROS_SVH
`define TYPED_VARINT_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold.
`define TVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define TVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TVE_ASSERT_NOW(lbl, ante, cons, msg)
`define TVE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/tve_pkg.sv
// ----------------------------------------------------------------------------
// tve_pkg
// Shared constants for the typed varint encoder.
// ----------------------------------------------------------------------------
package tve_pkg;

    localparam int BYTE_W     = 8;
    localparam int GROUP_BITS = 7;
    localparam int TAG_W      = 7;

    localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

    // configuration register indexes
    localparam logic REG_TAG_MASK = 1'b0;
    localparam logic REG_NEG_TAG  = 1'b1;

    localparam logic [TAG_W-1:0] TAG_MASK_RST = 7'd112;
    localparam logic [TAG_W-1:0] NEG_TAG_RST  = 7'd64;

endpackage

>>> hw/rtl/tve_encode.sv
// ----------------------------------------------------------------------------
// tve_encode
// Combinational varint encoder: magnitude, 7-bit groups, tag placement.
// ----------------------------------------------------------------------------
module tve_encode
    import tve_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  func,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [TAG_W-1:0]      type_tag,
    input  logic [TAG_W-1:0]      tag_mask,
    input  logic [TAG_W-1:0]      negative_tag,
    output logic [BYTE_W-1:0]     enc_bytes [(VALUE_BITS + 6) / 7 + 1],
    output logic [$clog2((VALUE_BITS + 6) / 7 + 2)-1:0] enc_cnt,
    output logic                  enc_err
);

    localparam int MAXR = (VALUE_BITS + 6) / 7 + 1;
    localparam int NG   = MAXR - 1;
    localparam int PW   = NG * GROUP_BITS;
    localparam int CW   = $clog2(MAXR + 1);

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [PW-1:0]         mag_pad;
    logic [CW-1:0]         n_grp;
    logic [CW-1:0]         n_tot;
    logic [TAG_W-1:0]      top_grp;
    logic [TAG_W-1:0]      tag;
    logic                  pre;

    assign neg     = value[VALUE_BITS-1];
    assign mag     = neg ? (~value + 1'b1) : value;
    assign mag_pad = PW'(mag);
    assign tag     = neg ? negative_tag : type_tag;

    // count significant groups and pick the top one
    always_comb
    begin
        n_grp   = CW'(1);
        top_grp = mag_pad[TAG_W-1:0];
        for (int j = 1; j < NG; j++)
        begin
            if (mag_pad[j*GROUP_BITS +: GROUP_BITS] != '0)
            begin
                n_grp   = CW'(j + 1);
                top_grp = mag_pad[j*GROUP_BITS +: GROUP_BITS];
            end
        end
    end

    assign pre   = func && ((top_grp & tag_mask) != '0);
    assign n_tot = n_grp + CW'(pre);

    // place group j at output slot k when j + k + 1 equals the total count
    always_comb
    begin
        for (int k = 0; k < MAXR; k++)
        begin
            enc_bytes[k] = '0;
            for (int j = 0; j < NG; j++)
            begin
                if ((j + k + 1 <= MAXR) && (n_tot == CW'(j + k + 1)))
                begin
                    enc_bytes[k] = {(j != 0), mag_pad[j*GROUP_BITS +: GROUP_BITS]};
                end
            end
        end
        if (pre)
        begin
            enc_bytes[0] = CONT_BIT | {1'b0, tag};
        end
        else if (func)
        begin
            enc_bytes[0] = enc_bytes[0] | {1'b0, tag};
        end
        enc_cnt = n_tot;
        enc_err = 1'b0;
        if (neg && !func)
        begin
            for (int k = 0; k < MAXR; k++)
            begin
                enc_bytes[k] = '0;
            end
            enc_cnt = CW'(1);
            enc_err = 1'b1;
        end
    end

endmodule

>>> hw/rtl/tve_serializer.sv
// ----------------------------------------------------------------------------
// tve_serializer
// Result register: holds one encoded value and shifts out a byte a transfer.
// ----------------------------------------------------------------------------
`include "typed_varint_encoder_macros.svh"

module tve_serializer
    import tve_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    output logic                  load_ready,
    input  logic [BYTE_W-1:0]     enc_bytes [(VALUE_BITS + 6) / 7 + 1],
    input  logic [$clog2((VALUE_BITS + 6) / 7 + 2)-1:0] enc_cnt,
    input  logic                  enc_err,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // out_byte
    output logic                  m_tlast,
    output logic                  m_tuser    // error
);

    localparam int MAXR = (VALUE_BITS + 6) / 7 + 1;
    localparam int CW   = $clog2(MAXR + 1);

    logic [BYTE_W-1:0] bytes_reg  [MAXR];
    logic [BYTE_W-1:0] bytes_next [MAXR];
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;
    logic              err_reg;
    logic              err_next;
    logic              xfer;

    assign m_tvalid   = (rem_reg != '0);
    assign m_tdata    = bytes_reg[0];
    assign m_tlast    = (rem_reg == CW'(1));
    assign m_tuser    = err_reg;
    assign xfer       = m_tvalid && m_tready;
    assign load_ready = !m_tvalid || (xfer && m_tlast);

    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        if (load)
        begin
            bytes_next = enc_bytes;
            rem_next   = enc_cnt;
            err_next   = enc_err;
        end
        else if (xfer)
        begin
            // advance to the next byte
            for (int k = 0; k < MAXR - 1; k++)
            begin
                bytes_next[k] = bytes_reg[k+1];
            end
            bytes_next[MAXR-1] = '0;
            rem_next           = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    `TVE_ASSERT_NOW(a_rem_range, 1'b1, rem_reg <= CW'(MAXR), "byte count beyond maximum")
    `TVE_ASSERT_NOW(a_err_single, m_tvalid && err_reg, m_tlast && (m_tdata == '0), "error result not a single zero byte")
    `TVE_ASSERT_NOW(a_cont_bit, m_tvalid && !m_tlast, m_tdata[BYTE_W-1], "continuation bit missing")
    `TVE_ASSERT_NOW(a_last_clear, m_tvalid && m_tlast, !m_tdata[BYTE_W-1], "final byte has continuation bit")
    `TVE_ASSERT_NEXT(a_rem_step, xfer && !m_tlast, rem_reg == $past(rem_reg) - CW'(1), "byte count did not advance")

endmodule

>>> hw/rtl/typed_varint_encoder.sv
// ----------------------------------------------------------------------------
// typed_varint_encoder
// Big-endian base-128 varint encoder with optional type tag, streaming I/O.
// ----------------------------------------------------------------------------
// Each input transfer carries one signed integer and yields one output
// transfer per encoded byte, most significant 7-bit group first, with tlast
// on the final byte and tuser set only for a negative value in count mode
// (one zero byte). An item yields N output bytes, where N is its byte
// count, 1 to (VALUE_BITS+6)/7+1 (6 at the default width). An input
// register holds the next item while the current one drains, so a new
// item is encoded and loaded in the same cycle the last byte of the
// previous one transfers, leaving no gap. tag_mask and negative_tag are
// to be written through the cfg port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "typed_varint_encoder_macros.svh"

module typed_varint_encoder
    import tve_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [TAG_W-1:0]       cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((VALUE_BITS + TAG_W + 7) / 8) * 8 - 1:0] s_tdata, // value, type_tag
    input  logic                   s_tuser,   // func
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // out_byte
    output logic                   m_tlast,   // last
    output logic                   m_tuser    // error
);

    localparam int MAXR = (VALUE_BITS + 6) / 7 + 1;
    localparam int CW   = $clog2(MAXR + 1);

    logic [TAG_W-1:0]      tag_mask_reg;
    logic [TAG_W-1:0]      neg_tag_reg;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  func_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [TAG_W-1:0]      tag_reg;

    logic                  s_xfer;
    logic                  load;
    logic                  load_ready;
    logic [BYTE_W-1:0]     enc_bytes [MAXR];
    logic [CW-1:0]         enc_cnt;
    logic                  enc_err;

    // Configuration registers: decode the index on a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_mask_reg <= TAG_MASK_RST;
            neg_tag_reg  <= NEG_TAG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAG_MASK: tag_mask_reg <= cfg_data;
                REG_NEG_TAG:  neg_tag_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register: take a new item whenever it is empty or its item moves
    // into the result register this cycle.
    assign load     = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || load_ready;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload of the accepted transfer.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            func_reg  <= s_tuser;
            value_reg <= s_tdata[VALUE_BITS-1:0];
            tag_reg   <= s_tdata[VALUE_BITS +: TAG_W];
        end
    end

    // Encode from the input register straight into the result register.
    tve_encode #(
        .VALUE_BITS (VALUE_BITS)
    ) u_encode (
        .func         (func_reg),
        .value        (value_reg),
        .type_tag     (tag_reg),
        .tag_mask     (tag_mask_reg),
        .negative_tag (neg_tag_reg),
        .enc_bytes    (enc_bytes),
        .enc_cnt      (enc_cnt),
        .enc_err      (enc_err)
    );

    tve_serializer #(
        .VALUE_BITS (VALUE_BITS)
    ) u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_ready (load_ready),
        .enc_bytes  (enc_bytes),
        .enc_cnt    (enc_cnt),
        .enc_err    (enc_err),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    `TVE_ASSERT_NEXT(a_in_capture, s_xfer, in_valid_reg, "accepted item not held")
    `TVE_ASSERT_NEXT(a_load_valid, load, m_tvalid, "loaded item produced no byte")
    `TVE_ASSERT_NOW(a_stall_full, in_valid_reg && !load_ready, !s_tready, "input taken while full")

endmodule

>>> verif/tve_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tve_checker
// Watches the config port and both streams of the typed varint encoder,
// predicts the byte sequence of every accepted value and compares each
// output transfer against it, counting failures for the testbench top.
// ----------------------------------------------------------------------------
module tve_checker
    import tve_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int IN_W       = ((VALUE_BITS + TAG_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [TAG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // value, type_tag
    input  logic              s_tuser,   // func
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,   // out_byte
    input  logic              m_tlast,   // last
    input  logic              m_tuser,   // error
    output int                fail_count,
    output int                outstanding
);

    localparam int MAX_BYTES = (VALUE_BITS + 6) / 7 + 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } varint_byte_t;

    logic [TAG_W-1:0] tag_mask_reg;
    logic [TAG_W-1:0] neg_tag_reg;
    varint_byte_t     expected_bytes[$];

    // Append the encoding of one value to the expected byte queue.
    function automatic void encode_varint(input logic typed,
                                          input logic [VALUE_BITS-1:0] value,
                                          input logic [TAG_W-1:0] tag);
        logic [BYTE_W-1:0]     groups[MAX_BYTES];
        logic [VALUE_BITS-1:0] mag;
        logic [TAG_W-1:0]      first_tag;
        varint_byte_t          item;
        int                    n;
        int                    k;
        mag       = value;
        first_tag = tag;
        if (value[VALUE_BITS-1] && !typed)
        begin
            item.data = '0;
            item.last = 1'b1;
            item.err  = 1'b1;
            expected_bytes.push_back(item);
            return;
        end
        if (value[VALUE_BITS-1])
        begin
            mag       = ~value + 1'b1;
            first_tag = neg_tag_reg;
        end
        groups[0] = {1'b0, mag[GROUP_BITS-1:0]};
        mag       = mag >> GROUP_BITS;
        n         = 1;
        while (mag != 0 && n < MAX_BYTES)
        begin
            groups[n] = CONT_BIT | {1'b0, mag[GROUP_BITS-1:0]};
            mag       = mag >> GROUP_BITS;
            n++;
        end
        if (typed)
        begin
            // reserved tag bits already taken: push a bare continuation byte in front
            if ((groups[n-1][TAG_W-1:0] & tag_mask_reg) != 0 && n < MAX_BYTES)
            begin
                groups[n] = CONT_BIT;
                n++;
            end
            groups[n-1] = groups[n-1] | {1'b0, first_tag};
        end
        for (k = 0; k < n; k++)
        begin
            item.data = groups[n-1-k];
            item.last = (k == n - 1);
            item.err  = 1'b0;
            expected_bytes.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        varint_byte_t want;
        if (!rst_n)
        begin
            tag_mask_reg = TAG_MASK_RST;
            neg_tag_reg  = NEG_TAG_RST;
            expected_bytes.delete();
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected output transfer: expected none, got %02h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        fail_count++;
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                    if (m_tuser !== want.err)
                    begin
                        fail_count++;
                        $display("%0t: error mismatch: expected %0b, got %0b",
                                 $time, want.err, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                encode_varint(s_tuser, s_tdata[VALUE_BITS-1:0],
                              s_tdata[VALUE_BITS +: TAG_W]);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TAG_MASK)
                    tag_mask_reg = cfg_data;
                else
                    neg_tag_reg = cfg_data;
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the typed varint encoder: directed edge values, then random
// values under several tag settings and idle/stall patterns, with a long
// receiver hold-off to back the block up. Checking lives in tve_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import tve_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int IN_W         = ((VALUE_BITS + TAG_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 12;      // idle margin after the last byte
    localparam int CYCLE_LIMIT  = 200000;   // watchdog, far beyond a slow run
    localparam int HOLD_CYCLES  = 300;      // long receiver back-pressure

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [TAG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // value, type_tag
    logic              s_tuser;    // func
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;    // out_byte
    logic              m_tlast;    // last
    logic              m_tuser;    // error

    int   fail_count;
    int   outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    logic hold_toggle = 1'b0;      // flip to request a receiver hold-off
    logic hold_seen   = 1'b0;      // last request taken by the receiver
    int   hold_left   = 0;         // hold-off cycles still to go

    typed_varint_encoder #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    tve_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Receiver: drive tready on the falling edge. A pending hold-off wins over
    // the random stall; count it down here on each falling edge.
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: count cycles and give up at the limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // Offer one value; return at the falling edge after its transfer.
    // Valid stays high across back-to-back items and drops only for a gap.
    task automatic send_item(input logic func, input logic [VALUE_BITS-1:0] value,
                             input logic [TAG_W-1:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {{(IN_W - VALUE_BITS - TAG_W){1'b0}}, tag, value};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Random value: spread the magnitude over all byte counts, flip the sign
    // about a third of the time, and now and then take a raw 32-bit word.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        int                    bits;
        if ($urandom_range(0, 7) == 0)
            return VALUE_BITS'($urandom);
        bits = $urandom_range(0, VALUE_BITS - 1);
        v = VALUE_BITS'($urandom) & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - 1 - bits));
        if ($urandom_range(0, 2) == 0)
            v = ~v + 1'b1;
        return v;
    endfunction

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            send_item(1'($urandom_range(0, 1)), random_value(),
                      TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
        end
    endtask

    // Stop offering, wait until every expected byte has arrived, then settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [TAG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_tags(input logic [TAG_W-1:0] mask, input logic [TAG_W-1:0] neg_tag);
        write_reg(REG_TAG_MASK, mask);
        write_reg(REG_NEG_TAG, neg_tag);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TAG_MASK;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, reset tags, no idling: byte-count boundaries, both signs,
        // count-mode errors, prefix byte, tag bits outside the mask.
        send_item(1'b0, 32'd0,          7'd0);
        send_item(1'b0, 32'd1,          7'h7f);
        send_item(1'b0, 32'd127,        7'd0);
        send_item(1'b0, 32'd128,        7'd0);
        send_item(1'b0, 32'd16383,      7'd0);
        send_item(1'b0, 32'd16384,      7'd0);
        send_item(1'b0, 32'h7fffffff,   7'd0);
        send_item(1'b0, 32'hffffffff,   7'd0);   // negative in count mode
        send_item(1'b0, 32'h80000000,   7'h7f);  // most negative in count mode
        send_item(1'b1, 32'd0,          7'h7f);  // zero carries only the tag
        send_item(1'b1, 32'd1,          7'd0);
        send_item(1'b1, 32'd15,         7'h70);  // fits under the mask
        send_item(1'b1, 32'd16,         7'h10);  // hits the mask: prefix byte
        send_item(1'b1, 32'd127,        7'h05);  // tag bits outside the mask
        send_item(1'b1, 32'hffffffff,   7'h33);  // negative: tag replaced
        send_item(1'b1, 32'h80000000,   7'h11);  // most negative, exact magnitude
        send_item(1'b1, 32'h7fffffff,   7'h7f);  // widest positive value, no prefix byte
        send_item(1'b1, 32'hffffff80,   7'h20);
        send_item(1'b1, 32'h0fffffff,   7'h0f);
        send_item(1'b1, 32'h00200000,   7'h00);
        drain();

        // All tag bits free, zero negative tag; no idling.
        set_tags(7'h00, 7'h00);
        send_random(40);
        drain();

        // Whole first byte reserved; sender mostly idle.
        set_tags(7'h7f, 7'h7f);
        send_idle_pct = 75;
        send_random(40);
        drain();

        // Random tags; receiver mostly stalled.
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        set_tags(TAG_W'($urandom_range(0, 127)), TAG_W'($urandom_range(0, 127)));
        send_random(40);
        // Long hold-off: keep offering so the block fills and stops accepting.
        @(posedge clk);
        hold_toggle = ~hold_toggle;
        @(negedge clk);
        send_random(20);
        drain();

        // Random tags; both sides idle now and then.
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        set_tags(TAG_W'($urandom_range(0, 127)), TAG_W'($urandom_range(0, 127)));
        send_random(40);
        drain();

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tve_pkg.sv
hw/rtl/tve_encode.sv
hw/rtl/tve_serializer.sv
hw/rtl/typed_varint_encoder.sv
verif/tve_checker.sv
verif/tb_top.sv
